FILE: rtl/core/imad_pkg.sv
`default_nettype none

package imad_pkg;

    localparam int unsigned PRED_W = 16;
    localparam int unsigned POS_W = 7;
    localparam int unsigned STEP_W = 15;
    localparam int unsigned DIFF_W = 17;
    localparam int unsigned ACC_W = 18;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [POS_W-1:0] STEP_MAX = 7'd88;

    typedef enum logic
    {
        REG_START_PRED = 1'b0,
        REG_START_POS  = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic signed [PRED_W-1:0] start_pred;
        logic [POS_W-1:0]         start_pos;
    } cfg_t;

    typedef struct packed
    {
        logic signed [PRED_W-1:0] pred;
        logic [POS_W-1:0]         pos;
    } dec_t;

    typedef struct packed
    {
        logic signed [PRED_W-1:0] sample;
        logic [POS_W-1:0]         step_after;
        logic                     last;
    } res_t;

    typedef struct packed
    {
        res_t       first;
        res_t       second;
        logic [1:0] cnt;
    } pair_t;

    localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [7:0] INDEX_MOVES [0:7] = '{
        -8'sd1, -8'sd1, -8'sd1, -8'sd1, 8'sd2, 8'sd4, 8'sd6, 8'sd8
    };

    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] pos);
        clamp_pos = (pos > STEP_MAX) ? STEP_MAX : pos;
    endfunction

    function automatic dec_t decode_nibble(
        input logic signed [PRED_W-1:0] pred,
        input logic [POS_W-1:0]         pos,
        input logic [3:0]               code
    );
        logic [STEP_W-1:0]       step;
        logic [DIFF_W-1:0]       diff;
        logic signed [ACC_W-1:0] acc;
        logic signed [7:0]       npos;
        dec_t                    r;
        step = STEP_TABLE[clamp_pos(pos)];
        diff = DIFF_W'(step >> 3);
        if (code[2])
        begin
            diff = diff + DIFF_W'(step);
        end
        if (code[1])
        begin
            diff = diff + DIFF_W'(step >> 1);
        end
        if (code[0])
        begin
            diff = diff + DIFF_W'(step >> 2);
        end
        if (code[3])
        begin
            acc = ACC_W'(pred) - $signed({1'b0, diff});
        end
        else
        begin
            acc = ACC_W'(pred) + $signed({1'b0, diff});
        end
        if (acc > 18'sd32767)
        begin
            r.pred = 16'sh7FFF;
        end
        else if (acc < -18'sd32768)
        begin
            r.pred = 16'sh8000;
        end
        else
        begin
            r.pred = acc[PRED_W-1:0];
        end
        npos = $signed({1'b0, clamp_pos(pos)}) + INDEX_MOVES[code[2:0]];
        if (npos < 8'sd0)
        begin
            r.pos = '0;
        end
        else if (npos > $signed({1'b0, STEP_MAX}))
        begin
            r.pos = STEP_MAX;
        end
        else
        begin
            r.pos = npos[POS_W-1:0];
        end
        decode_nibble = r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/imad_in_if.sv
`default_nettype none

interface imad_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       take_low;
    logic       take_high;
    logic       restart;

    modport source (output valid, output packed_byte, output take_low, output take_high,
                    output restart, input ready);
    modport sink (input valid, input packed_byte, input take_low, input take_high,
                  input restart, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/imad_out_if.sv
`default_nettype none

interface imad_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [6:0]         step_after;
    logic               last;

    modport source (output valid, output sample, output step_after, output last,
                    input ready);
    modport sink (input valid, input sample, input step_after, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/imad_cfg.sv
`default_nettype none

module imad_cfg
    import imad_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic signed [PRED_W-1:0] start_pred_reg;
    logic [POS_W-1:0]         start_pos_reg;
    logic                     wr_en;
    cfg_reg_t                 sel;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;
    assign sel = cfg_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pred_reg <= '0;
            start_pos_reg <= '0;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_START_PRED: start_pred_reg <= pwdata[PRED_W-1:0];
                REG_START_POS:  start_pos_reg <= pwdata[POS_W-1:0];
                default:        start_pred_reg <= start_pred_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_START_PRED: prdata = {{(APB_DATA_W-PRED_W){start_pred_reg[PRED_W-1]}},
                                      start_pred_reg};
            REG_START_POS:  prdata = {{(APB_DATA_W-POS_W){1'b0}}, start_pos_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.start_pred = start_pred_reg;
    assign cfg.start_pos = start_pos_reg;

endmodule

`default_nettype wire

FILE: rtl/core/imad_core.sv
`default_nettype none

module imad_core
    import imad_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    imad_in_if.sink   item_in,
    input  cfg_t      cfg,
    input  wire logic load_ok,
    output logic      advance,
    output pair_t     pair
);

    logic                     in_vld_reg;
    logic [7:0]               byte_reg;
    logic                     low_reg;
    logic                     high_reg;
    logic                     restart_reg;
    logic signed [PRED_W-1:0] pred_reg;
    logic [POS_W-1:0]         pos_reg;

    dec_t base;
    dec_t r_lo;
    dec_t mid;
    dec_t r_hi;
    dec_t fin;
    logic in_xfer;

    assign advance = in_vld_reg && load_ok;
    assign item_in.ready = !in_vld_reg || load_ok;
    assign in_xfer = item_in.valid && item_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_vld_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= item_in.packed_byte;
            low_reg <= item_in.take_low;
            high_reg <= item_in.take_high;
            restart_reg <= item_in.restart;
        end
    end

    always_comb
    begin
        if (restart_reg)
        begin
            base.pred = cfg.start_pred;
            base.pos = clamp_pos(cfg.start_pos);
        end
        else
        begin
            base.pred = pred_reg;
            base.pos = pos_reg;
        end
        r_lo = decode_nibble(base.pred, base.pos, byte_reg[3:0]);
        mid = low_reg ? r_lo : base;
        r_hi = decode_nibble(mid.pred, mid.pos, byte_reg[7:4]);
        fin = high_reg ? r_hi : mid;
    end

    always_comb
    begin
        pair.cnt = {1'b0, low_reg} + {1'b0, high_reg};
        pair.second.sample = r_hi.pred;
        pair.second.step_after = r_hi.pos;
        pair.second.last = 1'b1;
        if (low_reg)
        begin
            pair.first.sample = r_lo.pred;
            pair.first.step_after = r_lo.pos;
            pair.first.last = !high_reg;
        end
        else
        begin
            pair.first = pair.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg <= '0;
            pos_reg <= '0;
        end
        else if (advance)
        begin
            pred_reg <= fin.pred;
            pos_reg <= fin.pos;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/imad_outbuf.sv
`default_nettype none

module imad_outbuf
    import imad_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  pair_t      pair,
    output logic       load_ok,
    imad_out_if.source item_out
);

    res_t       slot0_reg;
    res_t       slot1_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign item_out.valid = (cnt_reg != 2'd0);
    assign item_out.sample = slot0_reg.sample;
    assign item_out.step_after = slot0_reg.step_after;
    assign item_out.last = slot0_reg.last;
    assign pop = item_out.valid && item_out.ready;
    assign load_ok = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && item_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (advance)
        begin
            cnt_reg <= pair.cnt;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot0_reg <= pair.first;
            slot1_reg <= pair.second;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ima_adpcm_nibble_decoder.sv
// ima adpcm 4-bit decoder, one packed byte per input transfer
// item_in carries packed_byte with take_low, take_high and restart; the low
// nibble is decoded first, then the high nibble, each only when enabled
// restart reloads predictor and step index from the two apb registers
// (start_predictor at 0x0, start_step_position at 0x4, index clamped to 88)
// before the byte is decoded
// item_out gives one transfer per decoded nibble: sample, step_after and
// last, which marks the final sample of its byte; a byte with no enabled
// nibble gives no output transfer
// an input transfer lands in the input register, is decoded combinationally
// from it and loaded into the result register, which offers its first sample
// throughput: one byte per cycle while each byte yields at most one sample
// and item_out is ready; the result register drains one sample per cycle
// while ready is high, so a byte with both nibbles holds it for both samples
// when item_out stalls, the result register and the input register fill and
// item_in.ready drops; nothing is lost
// reset clears predictor, step index, both apb registers and all valid state
`default_nettype none

module ima_adpcm_nibble_decoder
    import imad_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    imad_in_if.sink                    item_in,
    imad_out_if.source                 item_out
);

    cfg_t  cfg;
    pair_t pair;
    logic  advance;
    logic  load_ok;

    imad_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    imad_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_in),
        .cfg     (cfg),
        .load_ok (load_ok),
        .advance (advance),
        .pair    (pair)
    );

    imad_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .pair     (pair),
        .load_ok  (load_ok),
        .item_out (item_out)
    );

    a_two_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pair.cnt == 2'd2 |=> item_out.valid && !item_out.last)
        else $error("first sample of a two-nibble byte marked last");

    a_empty_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pair.cnt == 2'd0 && !item_out.valid |=> !item_out.valid)
        else $error("sample produced for a byte with no enabled nibble");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_out.valid |-> item_out.step_after <= STEP_MAX)
        else $error("step index out of range");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pair.cnt != 2'd0 |=> item_out.valid)
        else $error("decoded byte lost in result stage");

endmodule

`default_nettype wire

FILE: verif/tb_ima_adpcm_nibble_decoder.sv
`timescale 1ns / 1ps

module tb_ima_adpcm_nibble_decoder;
    import imad_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_BYTES = 160;
    localparam int NUM_PHASES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP = 40;

    class nibble_scoreboard;
        localparam int MAX_PRINTS = 100;

        logic signed [PRED_W-1:0] start_pred;
        logic [POS_W-1:0]         start_pos;
        logic signed [PRED_W-1:0] pred;
        logic [POS_W-1:0]         pos;
        res_t                     pending[$];
        int                       mismatches;
        int                       bytes_seen;
        int                       restarts;
        int                       samples_checked;
        int                       saturated;

        function new();
            start_pred = '0;
            start_pos = '0;
            pred = '0;
            pos = '0;
            mismatches = 0;
            bytes_seen = 0;
            restarts = 0;
            samples_checked = 0;
            saturated = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [APB_DATA_W-1:0] v);
            if (r == REG_START_PRED)
            begin
                start_pred = v[PRED_W-1:0];
            end
            else
            begin
                start_pos = v[POS_W-1:0];
            end
        endfunction

        function void decode_code(logic [3:0] code, logic last);
            int   step;
            int   diff;
            int   acc;
            int   npos;
            res_t e;
            step = int'(STEP_TABLE[pos]);
            diff = step >>> 3;
            if (code[2]) diff += step;
            if (code[1]) diff += step >>> 1;
            if (code[0]) diff += step >>> 2;
            acc = code[3] ? int'(pred) - diff : int'(pred) + diff;
            if (acc > 32767 || acc < -32768)
            begin
                saturated++;
            end
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            pred = PRED_W'(acc);
            npos = code[2] ? int'(pos) + 2 * (int'(code[1:0]) + 1) : int'(pos) - 1;
            if (npos < 0) npos = 0;
            if (npos > int'(STEP_MAX)) npos = int'(STEP_MAX);
            pos = POS_W'(npos);
            e.sample = pred;
            e.step_after = pos;
            e.last = last;
            pending.push_back(e);
        endfunction

        function void note_byte(logic [7:0] b, logic tl, logic th, logic rs);
            bytes_seen++;
            if (rs)
            begin
                restarts++;
                pred = start_pred;
                pos = (start_pos > STEP_MAX) ? STEP_MAX : start_pos;
            end
            if (tl) decode_code(b[3:0], !th);
            if (th) decode_code(b[7:4], 1'b1);
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
            begin
                $display("mismatch in %s at %0t: got %0d, expected %0d", what, $time, got, want);
            end
        endtask

        task check_sample(logic signed [PRED_W-1:0] s, logic [POS_W-1:0] sa, logic l);
            res_t e;
            samples_checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected sample", int'(s), 0);
                return;
            end
            e = pending.pop_front();
            if (s !== e.sample) report_mismatch("sample", int'(s), int'(e.sample));
            if (sa !== e.step_after) report_mismatch("step_after", int'(sa), int'(e.step_after));
            if (l !== e.last) report_mismatch("last", int'(l), int'(e.last));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  hold_off;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    settings_used;
    nibble_scoreboard      sb;

    imad_in_if in_bus();
    imad_out_if out_bus();

    ima_adpcm_nibble_decoder i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .item_in  (in_bus),
        .item_out (out_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_HALF) clk = ~clk;
        end
    end

    task automatic write_reg(cfg_reg_t r, logic [APB_DATA_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(int'(r) * 4);
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(r, v);
    endtask

    task automatic drain_outputs();
        in_bus.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [PRED_W-1:0] p, logic [POS_W-1:0] q);
        drain_outputs();
        write_reg(REG_START_PRED, {16'($urandom), p});
        write_reg(REG_START_POS, {25'($urandom), q});
        settings_used++;
    endtask

    task automatic send_byte(logic [7:0] b, logic tl, logic th, logic rs);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.packed_byte <= b;
        in_bus.take_low <= tl;
        in_bus.take_high <= th;
        in_bus.restart <= rs;
        do @(posedge clk); while (!in_bus.ready);
        sb.note_byte(b, tl, th, rs);
    endtask

    // restart first, may begin on a high nibble and end on a low one
    task automatic send_stream(int len);
        logic tl;
        logic th;
        for (int k = 0; k < len; k++)
        begin
            tl = (k == 0) ? 1'($urandom_range(1)) : 1'b1;
            th = (k == len - 1) ? 1'($urandom_range(1)) : 1'b1;
            send_byte(8'($urandom_range(255)), tl, th, k == 0);
        end
    endtask

    task automatic hold_receiver(int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    initial
    begin : result_sink
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_bus.valid && out_bus.ready)
            begin
                sb.check_sample(out_bus.sample, out_bus.step_after, out_bus.last);
            end
            out_bus.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : main_seq
        int pv;
        int qv;
        int target;
        bit paused;
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_bus.valid = 1'b0;
        in_bus.packed_byte = '0;
        in_bus.take_low = 1'b0;
        in_bus.take_high = 1'b0;
        in_bus.restart = 1'b0;
        out_bus.ready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        settings_used = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // from reset state
        send_byte(8'h00, 1'b1, 1'b1, 1'b0);
        send_byte(8'h77, 1'b1, 1'b1, 1'b0);
        send_byte(8'h77, 1'b1, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1, 1'b0);
        send_byte(8'h08, 1'b1, 1'b1, 1'b0);
        send_byte(8'h80, 1'b1, 1'b0, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b1, 1'b0);
        // restart with no nibble, then check it took effect
        send_byte(8'hA5, 1'b0, 1'b0, 1'b1);
        send_byte(8'h11, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b1, 1'b1, 1'b0);

        configure(16'sh7FFF, 7'd88);
        send_byte(8'h77, 1'b1, 1'b1, 1'b1);
        send_byte(8'h07, 1'b1, 1'b0, 1'b1);
        send_byte(8'hF7, 1'b1, 1'b1, 1'b0);
        send_byte(8'h70, 1'b0, 1'b1, 1'b1);

        // start index above the table end
        configure(16'sh8000, 7'd127);
        send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
        send_byte(8'h88, 1'b1, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b1, 1'b1);
        send_byte(8'h4C, 1'b0, 1'b1, 1'b1);
        send_byte(8'hC4, 1'b1, 1'b1, 1'b0);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    pv = 0;
                    qv = 0;
                end
                1:
                begin
                    pv = 32767;
                    qv = 88;
                end
                2:
                begin
                    pv = -32768;
                    qv = 127;
                end
                3:
                begin
                    pv = $urandom_range(65535);
                    qv = 89;
                end
                default:
                begin
                    pv = $urandom_range(65535);
                    qv = $urandom_range(127);
                end
            endcase
            configure(PRED_W'(pv), POS_W'(qv));
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 65;
                end
                default:
                begin
                    send_idle_pct = 9;
                    recv_stall_pct <= 9;
                end
            endcase
            if (ph % 4 == 0)
            begin
                fork
                    hold_receiver(HOLD_CYCLES);
                join_none
            end
            target = sb.bytes_seen + PHASE_BYTES;
            paused = 1'b0;
            while (sb.bytes_seen < target)
            begin
                if (ph == 5 && !paused && sb.bytes_seen >= target - PHASE_BYTES / 2)
                begin
                    paused = 1'b1;
                    in_bus.valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
                if ($urandom_range(9) < 8)
                begin
                    send_stream($urandom_range(1, 24));
                end
                else
                begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
        end

        drain_outputs();
        $display("covered %0d bytes (%0d with restart) and %0d samples, %0d of them saturated",
                 sb.bytes_seen, sb.restarts, sb.samples_checked, sb.saturated);
        $display("over %0d register settings and four pacing modes with back-pressure",
                 settings_used);
        if (sb.mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
